[hw/rtl/bba_pkg.sv]
`default_nettype none

package bba_pkg;

    localparam int REQ_W = 17;
    localparam int ADDR_W = 16;
    localparam int ORDER_W = 5;
    localparam int HEAP_LOG2_DEFAULT = 16;

    typedef struct packed {
        logic load;
        logic take;
        logic split;
        logic respond;
        logic fail;
    } cmd_t;

    typedef struct packed {
        logic too_big;
        logic found_any;
        logic at_want;
        logic out_free;
    } status_t;

    // Smallest order whose block holds the given number of words.
    function automatic logic [ORDER_W-1:0] size_to_order(input logic [REQ_W-1:0] size);
        logic [REQ_W-1:0] m;
        logic [ORDER_W-1:0] o;
        m = size - REQ_W'(1);
        o = '0;
        if (size > REQ_W'(1))
        begin
            for (int i = 0; i < REQ_W; i++)
            begin
                if (m[i])
                begin
                    o = ORDER_W'(i + 1);
                end
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bba_datapath.sv]
`default_nettype none

module bba_datapath #(
    parameter int HEAP_WORDS_LOG2 = bba_pkg::HEAP_LOG2_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [bba_pkg::REQ_W-1:0]      request_size,
    input  wire logic                           rsp_stall,
    input  wire bba_pkg::cmd_t                  cmd,
    output bba_pkg::status_t                    status,
    output logic                                rsp_valid,
    output logic [bba_pkg::ADDR_W-1:0]          block_address,
    output logic                                alloc_fail
);

    localparam int NORD = HEAP_WORDS_LOG2 + 1;
    localparam int IDX_W = $clog2(NORD);
    localparam int BASE_W = HEAP_WORDS_LOG2;

    logic [NORD-1:0]               valid_reg;
    logic [NORD-1:0]               valid_next;
    logic [BASE_W-1:0]             base_mem_reg [NORD];
    logic [bba_pkg::ORDER_W-1:0]   want_reg;
    logic [bba_pkg::ORDER_W-1:0]   want_next;
    logic                          big_reg;
    logic                          big_next;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic [BASE_W-1:0]             base_reg;
    logic [BASE_W-1:0]             base_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic [bba_pkg::ADDR_W-1:0]    addr_reg;
    logic [bba_pkg::ADDR_W-1:0]    addr_next;
    logic                          oom_reg;
    logic                          oom_next;

    logic [NORD-1:0]               cand;
    logic                          found_any;
    logic [IDX_W-1:0]              found_idx;
    logic [IDX_W-1:0]              idx_m1;
    logic [bba_pkg::ORDER_W-1:0]   req_order;

    assign req_order = bba_pkg::size_to_order(request_size);
    assign idx_m1 = idx_reg - IDX_W'(1);

    always_comb
    begin
        for (int i = 0; i < NORD; i++)
        begin
            cand[i] = valid_reg[i] && (32'(want_reg) <= 32'(i));
        end
        found_any = |cand;
        found_idx = '0;
        for (int i = NORD - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found_idx = IDX_W'(i);
            end
        end
    end

    assign status.too_big = big_reg;
    assign status.found_any = found_any;
    assign status.at_want = (bba_pkg::ORDER_W'(idx_reg) == want_reg);
    assign status.out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        want_next = want_reg;
        big_next = big_reg;
        idx_next = idx_reg;
        base_next = base_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        addr_next = addr_reg;
        oom_next = oom_reg;
        if (cmd.load)
        begin
            want_next = req_order;
            big_next = (32'(req_order) > 32'(HEAP_WORDS_LOG2));
        end
        if (cmd.take)
        begin
            valid_next[found_idx] = 1'b0;
            base_next = base_mem_reg[found_idx];
            idx_next = found_idx;
        end
        if (cmd.split)
        begin
            valid_next[idx_m1] = 1'b1;
            base_next = base_reg + (BASE_W'(1) << idx_m1);
            idx_next = idx_m1;
        end
        if (cmd.respond)
        begin
            rsp_valid_next = 1'b1;
            oom_next = cmd.fail;
            addr_next = cmd.fail ? '0 : bba_pkg::ADDR_W'(base_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= NORD'(1) << HEAP_WORDS_LOG2;
            for (int i = 0; i < NORD; i++)
            begin
                base_mem_reg[i] <= '0;
            end
            want_reg <= '0;
            big_reg <= 1'b0;
            idx_reg <= '0;
            base_reg <= '0;
            rsp_valid_reg <= 1'b0;
            addr_reg <= '0;
            oom_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.split)
            begin
                base_mem_reg[idx_m1] <= base_reg;
            end
            want_reg <= want_next;
            big_reg <= big_next;
            idx_reg <= idx_next;
            base_reg <= base_next;
            rsp_valid_reg <= rsp_valid_next;
            addr_reg <= addr_next;
            oom_reg <= oom_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign block_address = addr_reg;
    assign alloc_fail = oom_reg;

    a_split_above_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split |-> idx_reg != '0)
        else $error("split requested at order zero");

    a_take_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (found_any && !big_reg))
        else $error("take without a free block of sufficient order");

    a_split_leaves_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split |=> valid_reg[$past(idx_m1)])
        else $error("lower half not marked free after split");

    a_oom_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && oom_reg) |-> addr_reg == '0)
        else $error("failed allocation carries a non-zero address");

endmodule

`default_nettype wire

[hw/rtl/bba_ctrl.sv]
`default_nettype none

module bba_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire bba_pkg::status_t   status,
    output bba_pkg::cmd_t           cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SPLIT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       fail_reg;
    logic       fail_next;

    always_comb
    begin
        state_next = state_reg;
        fail_next = fail_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.too_big || !status.found_any)
                begin
                    fail_next = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.take = 1'b1;
                    fail_next = 1'b0;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (status.at_want)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.split = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.respond = 1'b1;
                    cmd.fail = fail_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fail_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fail_reg <= fail_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    a_respond_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |-> status.out_free)
        else $error("result written while the output register is held");

    a_load_then_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_SEARCH)
        else $error("accepted request did not start a search");

    a_fail_no_split: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && status.too_big) |=> state_reg == S_FINISH && fail_reg)
        else $error("oversized request not reported as out of memory");

endmodule

`default_nettype wire

[hw/rtl/buddy_block_allocator_core.sv]
// Allocation-only buddy allocator over a heap of 2^HEAP_WORDS_LOG2 words.
// Request channel: req_valid, req_stall and request_size. A transfer takes
// place at a rising edge with req_valid high and req_stall low. The size is
// rounded up to a power of two; a size of zero is served as one word.
// Result channel: rsp_valid, rsp_stall, block_address and alloc_fail.
// Exactly one result follows each request. On failure the address is zero.
// One request is handled at a time. A request is loaded; the order search,
// which is combinational, then takes the smallest free block of sufficient
// order or flags a failure, and the splitting loop halves that block, one
// order per cycle, down to the requested order before the result is written.
// The next request can be taken in the cycle after the result is written.
// A stalled result is held in the output register; the block completes the
// current request and then waits before writing the next result.
// Reset leaves one free block covering the whole heap at address zero.
`default_nettype none

module buddy_block_allocator_core #(
    parameter int HEAP_WORDS_LOG2 = bba_pkg::HEAP_LOG2_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic [bba_pkg::REQ_W-1:0]  request_size,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic [bba_pkg::ADDR_W-1:0]      block_address,
    output logic                            alloc_fail
);

    bba_pkg::cmd_t    cmd;
    bba_pkg::status_t status;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bba_datapath #(
        .HEAP_WORDS_LOG2 (HEAP_WORDS_LOG2)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_size  (request_size),
        .rsp_stall     (rsp_stall),
        .cmd           (cmd),
        .status        (status),
        .rsp_valid     (rsp_valid),
        .block_address (block_address),
        .alloc_fail    (alloc_fail)
    );

endmodule

`default_nettype wire
